### hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared codes, defaults and control bundles of the block bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BITMAP_BYTES_DEF = 4096;

    // request codes
    localparam logic [2:0] ACT_ONE   = 3'd0;
    localparam logic [2:0] ACT_NEXT  = 3'd1;
    localparam logic [2:0] ACT_EIGHT = 3'd2;
    localparam logic [2:0] ACT_RUN   = 3'd3;
    localparam logic [2:0] ACT_LOAD  = 3'd4;
    localparam logic [2:0] ACT_READ  = 3'd5;
    localparam logic [2:0] ACT_SET   = 3'd6;

    // register indexes
    localparam logic [1:0] REG_NUM_BLOCKS = 2'd0;
    localparam logic [1:0] REG_AG_SHIFT   = 2'd1;
    localparam logic [1:0] REG_NUM_AGS    = 2'd2;

    localparam logic [15:0] NUM_BLOCKS_RST = 16'd0;
    localparam logic [3:0]  AG_SHIFT_RST   = 4'd11;
    localparam logic [12:0] NUM_AGS_RST    = 13'd16;

    typedef struct packed {
        logic accept;
        logic setup;
        logic rd;
        logic step;
        logic phase;
        logic hit;
        logic wr;
        logic wstep;
        logic rbyte;
        logic rlatch;
        logic fin;
    } bba_cmd_t;

    typedef struct packed {
        logic setup_fail;
        logic hit;
        logic last;
        logic phase_b_ok;
        logic wr_last;
        logic idx_ok;
    } bba_stat_t;

endpackage

### hw/rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: setup, byte scan, bitmap update, byte read and result.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] action,
    input  bba_stat_t  stat,
    output bba_cmd_t   cmd,
    output logic       busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_SRD   = 3'd2;
    localparam logic [2:0] ST_SCHK  = 3'd3;
    localparam logic [2:0] ST_WR    = 3'd4;
    localparam logic [2:0] ST_BRD   = 3'd5;
    localparam logic [2:0] ST_BWT   = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (action inside {ACT_ONE, ACT_NEXT, ACT_EIGHT, ACT_RUN})
                        state_next = ST_SETUP;
                    else if (action == ACT_READ && stat.idx_ok)
                        state_next = ST_BRD;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.setup_fail ? ST_FIN : ST_SRD;
            end
            ST_SRD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (stat.hit)
                begin
                    cmd.hit    = 1'b1;
                    state_next = ST_WR;
                end
                else if (stat.last)
                begin
                    if (stat.phase_b_ok)
                    begin
                        cmd.phase  = 1'b1;
                        state_next = ST_SRD;
                    end
                    else
                        state_next = ST_FIN;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_SRD;
                end
            end
            ST_WR:
            begin
                cmd.wr = 1'b1;
                if (stat.wr_last)
                    state_next = ST_FIN;
                else
                    cmd.wstep = 1'b1;
            end
            ST_BRD:
            begin
                cmd.rbyte  = 1'b1;
                state_next = ST_BWT;
            end
            ST_BWT:
            begin
                cmd.rlatch = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hw/rtl/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap memory, configuration, scan window, run counter and result registers.
// ----------------------------------------------------------------------------
module bba_datapath
    import bba_pkg::*;
#(
    parameter int BITMAP_BYTES = BITMAP_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  bba_cmd_t    cmd,
    output bba_stat_t   stat,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [2:0]  action,
    input  logic [11:0] group,
    input  logic [15:0] run_length,
    input  logic [11:0] byte_index,
    input  logic [7:0]  byte_data,
    input  logic [15:0] used_value,
    output logic        done,
    output logic        ok,
    output logic [11:0] out_group,
    output logic [14:0] out_start,
    output logic [15:0] out_length,
    output logic [7:0]  byte_out,
    output logic [15:0] used_count
);

    localparam int AW  = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int CAP = BITMAP_BYTES * 8;

    logic [7:0] mem [BITMAP_BYTES];
    logic [7:0] rd_data_reg;

    logic [15:0] nblk_reg;
    logic [3:0]  shift_reg;
    logic [12:0] nags_reg;
    logic [15:0] used_reg;
    logic [11:0] lastg_reg;

    logic [2:0]  act_reg;
    logic [11:0] grp_reg;
    logic [15:0] len_reg;
    logic [11:0] idx_reg;

    logic [15:0] lo_reg;
    logic [15:0] hi_reg;
    logic [15:0] hib_reg;
    logic        phase_b_reg;
    logic [12:0] p_reg;
    logic [13:0] k_reg;
    logic [13:0] run_reg;
    logic [12:0] wp_reg;
    logic [12:0] wi_reg;
    logic [7:0]  wone_reg;
    logic [15:0] blk_reg;
    logic [15:0] len_out_reg;
    logic        ok_reg;
    logic [7:0]  bout_reg;

    logic        done_reg;
    logic        ok_o_reg;
    logic [11:0] grp_o_reg;
    logic [14:0] start_o_reg;
    logic [15:0] len_o_reg;
    logic [7:0]  bout_o_reg;
    logic [15:0] used_o_reg;

    // mode and derived search values
    logic        mode_one;
    logic        mode_eight;
    logic        mode_run;
    logic [15:0] n_c;
    logic [12:0] f_c;
    logic [26:0] sb_c;
    logic [15:0] b_c;
    logic [23:0] s_raw;
    logic [12:0] s_c;
    logic [16:0] len7_c;
    logic [13:0] k_c;
    logic [16:0] used8_c;
    logic        fail_c;
    logic [15:0] lo_a;
    logic [15:0] hi_a;
    logic [15:0] hi_b;
    logic [12:0] ng_c;
    logic [12:0] lastg_inc;

    // byte check
    logic [15:0] hi_m1;
    logic [12:0] last_c;
    logic [7:0]  free_c;
    logic [2:0]  j_c;
    logic [13:0] run_next;
    logic        hit_c;
    logic [12:0] from_c;
    logic [12:0] waddr_c;
    logic [7:0]  wdata_c;
    logic [7:0]  part_c;
    logic [15:0] got_c;
    logic [16:0] sum_c;
    logic [15:0] blk_mask;
    logic [15:0] blk_grp;

    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic        mem_re;
    logic [AW-1:0] mem_raddr;

    assign mode_one   = (act_reg == ACT_ONE) || (act_reg == ACT_NEXT)
                        || (act_reg == ACT_RUN && len_reg == 16'd1);
    assign mode_eight = (act_reg == ACT_EIGHT);
    assign mode_run   = (act_reg == ACT_RUN) && (len_reg != 16'd1);

    assign n_c     = (32'(nblk_reg) < CAP) ? nblk_reg : 16'(CAP);
    assign f_c     = n_c[15:3];
    assign sb_c    = 27'(grp_reg) << shift_reg;
    assign b_c     = (sb_c >= 27'(n_c)) ? 16'd0 : sb_c[15:0];
    assign s_raw   = sb_c[26:3];
    assign s_c     = (s_raw < 24'(f_c)) ? s_raw[12:0] : 13'd0;
    assign len7_c  = 17'(len_reg) + 17'd7;
    assign k_c     = len7_c[16:3];
    assign used8_c = 17'(used_reg) + 17'd8;

    always_comb
    begin
        if (mode_one)
            fail_c = (used_reg >= n_c);
        else if (mode_eight)
            fail_c = (used8_c > 17'(n_c)) || (f_c == 13'd0);
        else
            fail_c = (len_reg == 16'd0) || (len_reg > n_c) || (k_c > 14'(f_c));
    end

    assign lo_a = mode_one ? b_c : {s_c, 3'b000};
    assign hi_a = mode_one ? n_c : {f_c, 3'b000};
    assign hi_b = mode_one ? b_c : (mode_eight ? {s_c, 3'b000} : {f_c, 3'b000});

    // round robin group
    assign lastg_inc = 13'(lastg_reg) + 13'd1;
    assign ng_c      = (nags_reg == 13'd0 || lastg_inc >= nags_reg) ? 13'd0 : lastg_inc;

    assign hi_m1  = hi_reg - 16'd1;
    assign last_c = hi_m1[15:3];

    always_comb
    begin
        logic [15:0] blkj;
        for (int j = 0; j < 8; j++)
        begin
            blkj      = {p_reg, 3'(j)};
            free_c[j] = (blkj >= lo_reg) && (blkj < hi_reg) && !rd_data_reg[7 - j];
        end
        j_c = 3'd0;
        for (int j = 7; j >= 0; j--)
        begin
            if (free_c[j])
                j_c = 3'(j);
        end
    end

    assign run_next = (rd_data_reg == 8'd0) ? run_reg + 14'd1 : 14'd0;
    assign from_c   = 13'(14'(p_reg) + 14'd1 - k_reg);

    always_comb
    begin
        if (mode_one)
            hit_c = |free_c;
        else if (mode_eight)
            hit_c = (rd_data_reg == 8'd0);
        else
            hit_c = (run_next >= k_reg);
    end

    always_comb
    begin
        if (mode_one)
            got_c = 16'd1;
        else if (mode_eight)
            got_c = 16'd8;
        else
            got_c = len_reg;
    end

    assign sum_c = 17'(used_reg) + 17'(got_c);

    // tail byte of a run takes the top len%8 bits
    assign part_c  = 8'(9'h1FF << (4'd8 - {1'b0, len_reg[2:0]}));
    assign waddr_c = wp_reg + wi_reg;

    always_comb
    begin
        if (mode_one)
            wdata_c = wone_reg;
        else if (mode_eight || 14'(wi_reg) < 14'(len_reg[15:3]))
            wdata_c = 8'hFF;
        else
            wdata_c = part_c;
    end

    assign stat.setup_fail = fail_c;
    assign stat.hit        = hit_c;
    assign stat.last       = (p_reg == last_c);
    assign stat.phase_b_ok = !phase_b_reg && (hib_reg != 16'd0);
    assign stat.wr_last    = !mode_run || (14'(wi_reg) == k_reg - 14'd1);
    assign stat.idx_ok     = (32'(byte_index) < BITMAP_BYTES);

    // bitmap memory
    assign mem_we    = (cmd.accept && action == ACT_LOAD && stat.idx_ok) || cmd.wr;
    assign mem_waddr = cmd.wr ? AW'(waddr_c) : AW'(byte_index);
    assign mem_wdata = cmd.wr ? wdata_c : byte_data;
    assign mem_re    = cmd.rd || cmd.rbyte;
    assign mem_raddr = cmd.rbyte ? AW'(idx_reg) : AW'(p_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // configuration and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nblk_reg  <= NUM_BLOCKS_RST;
            shift_reg <= AG_SHIFT_RST;
            nags_reg  <= NUM_AGS_RST;
            used_reg  <= 16'd0;
            lastg_reg <= 12'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_BLOCKS: nblk_reg  <= cfg_data;
                    REG_AG_SHIFT:   shift_reg <= cfg_data[3:0];
                    REG_NUM_AGS:    nags_reg  <= cfg_data[12:0];
                    default:        ;
                endcase
            end
            if (cmd.accept && action == ACT_NEXT)
                lastg_reg <= ng_c[11:0];
            if (cmd.accept && action == ACT_SET)
                used_reg <= used_value;
            else if (cmd.hit)
                used_reg <= sum_c[16] ? 16'hFFFF : sum_c[15:0];
            done_reg <= cmd.fin;
        end
    end

    // item and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg     <= action;
            grp_reg     <= (action == ACT_NEXT) ? ng_c[11:0] : group;
            len_reg     <= run_length;
            idx_reg     <= byte_index;
            blk_reg     <= 16'd0;
            len_out_reg <= 16'd0;
            bout_reg    <= 8'd0;
            ok_reg      <= (action == ACT_SET) || (action == ACT_LOAD && stat.idx_ok);
        end
        if (cmd.setup)
        begin
            lo_reg      <= lo_a;
            hi_reg      <= hi_a;
            hib_reg     <= hi_b;
            p_reg       <= lo_a[15:3];
            k_reg       <= k_c;
            run_reg     <= 14'd0;
            phase_b_reg <= 1'b0;
        end
        if (cmd.step)
        begin
            p_reg   <= p_reg + 13'd1;
            run_reg <= run_next;
        end
        if (cmd.phase)
        begin
            lo_reg      <= 16'd0;
            hi_reg      <= hib_reg;
            p_reg       <= 13'd0;
            run_reg     <= 14'd0;
            phase_b_reg <= 1'b1;
        end
        if (cmd.hit)
        begin
            ok_reg      <= 1'b1;
            len_out_reg <= got_c;
            wi_reg      <= 13'd0;
            wone_reg    <= rd_data_reg | (8'h80 >> j_c);
            if (mode_one)
            begin
                blk_reg <= {p_reg, j_c};
                wp_reg  <= p_reg;
            end
            else if (mode_eight)
            begin
                blk_reg <= {p_reg, 3'b000};
                wp_reg  <= p_reg;
            end
            else
            begin
                blk_reg <= {from_c, 3'b000};
                wp_reg  <= from_c;
            end
        end
        if (cmd.wstep)
            wi_reg <= wi_reg + 13'd1;
        if (cmd.rlatch)
        begin
            bout_reg <= rd_data_reg;
            ok_reg   <= 1'b1;
        end
    end

    // result registers
    assign blk_mask = (16'd1 << shift_reg) - 16'd1;
    assign blk_grp  = blk_reg >> shift_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            ok_o_reg    <= ok_reg;
            grp_o_reg   <= blk_grp[11:0];
            start_o_reg <= blk_reg[14:0] & blk_mask[14:0];
            len_o_reg   <= len_out_reg;
            bout_o_reg  <= bout_reg;
            used_o_reg  <= used_reg;
        end
    end

    assign done       = done_reg;
    assign ok         = ok_o_reg;
    assign out_group  = grp_o_reg;
    assign out_start  = start_o_reg;
    assign out_length = len_o_reg;
    assign byte_out   = bout_o_reg;
    assign used_count = used_o_reg;

endmodule

### hw/rtl/block_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// Disk block allocator over a used-block bitmap held in on-chip memory.
// ----------------------------------------------------------------------------
// One item at a time: an item is taken when start is high and busy is low, and
// its result appears for exactly one cycle with done high; it must be captured
// then. An allocation runs setup, then scans bitmap bytes with one memory read
// and one check per byte, from the group's first byte with wrap-around, then
// writes the bytes back and gives its result; a run of len blocks writes
// ceil(len/8) bytes. The bitmap memory has no reset and must be loaded before
// allocating.
module block_bitmap_allocator_unit
    import bba_pkg::*;
#(
    parameter int BITMAP_BYTES = BITMAP_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [2:0]  action,
    input  logic [11:0] group,
    input  logic [15:0] run_length,
    input  logic [11:0] byte_index,
    input  logic [7:0]  byte_data,
    input  logic [15:0] used_value,
    output logic        ok,
    output logic [11:0] out_group,
    output logic [14:0] out_start,
    output logic [15:0] out_length,
    output logic [7:0]  byte_out,
    output logic [15:0] used_count
);

    bba_cmd_t  cmd;
    bba_stat_t stat;

    bba_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    bba_datapath #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .action     (action),
        .group      (group),
        .run_length (run_length),
        .byte_index (byte_index),
        .byte_data  (byte_data),
        .used_value (used_value),
        .done       (done),
        .ok         (ok),
        .out_group  (out_group),
        .out_start  (out_start),
        .out_length (out_length),
        .byte_out   (byte_out),
        .used_count (used_count)
    );

endmodule
